// ----- hw/rtl/tkw_pkg.sv -----
// ---------------------------------------------------------------------------
// tkw_pkg: shared types and constants of the table-keyed word cipher
// Beat layouts, request codes, configuration indexes and the table
// request that goes between the sequencer and the table banks.
// ---------------------------------------------------------------------------
`default_nettype none

package tkw_pkg;

  // Field widths fixed by the beat formats
  localparam int unsigned WORD_W    = 32;
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned TIDX_W    = 16;
  localparam int unsigned BLOCK_W   = 13;
  localparam int unsigned LANES     = 4;
  localparam int unsigned TBL_DEPTH = 65536;

  // Request codes
  localparam logic [1:0] REQ_LOAD    = 2'd0;
  localparam logic [1:0] REQ_WORD    = 2'd1;
  localparam logic [1:0] REQ_RESTART = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] CFG_MODE         = 2'd0;
  localparam logic [1:0] CFG_BLOCK_WORDS  = 2'd1;
  localparam logic [1:0] CFG_START_KEY    = 2'd2;
  localparam logic [1:0] CFG_START_SUBKEY = 2'd3;

  typedef struct packed {
    logic [1:0]        req_type;
    logic [TIDX_W-1:0] table_index;
    logic [BYTE_W-1:0] table_byte;
    logic [WORD_W-1:0] data_word;
  } req_t;

  typedef struct packed {
    logic [WORD_W-1:0] data_out;
    logic              block_last;
  } rsp_t;

  typedef struct packed {
    logic               cipher_mode;
    logic [BLOCK_W-1:0] block_words;
    logic [WORD_W-1:0]  start_key;
    logic [WORD_W-1:0]  start_subkey;
  } cfg_t;

  // One write port shared by all banks, one read address per bank
  typedef struct packed {
    logic                         we;
    logic [TIDX_W-1:0]            waddr;
    logic [BYTE_W-1:0]            wdata;
    logic                         re;
    logic [LANES-1:0][TIDX_W-1:0] raddr;
  } tbl_req_t;

  typedef struct packed {
    logic busy;
    logic emit;
  } seq_stat_t;

endpackage

`default_nettype wire

// ----- hw/rtl/tkw_table.sv -----
// ---------------------------------------------------------------------------
// tkw_table: substitution table in four read banks
// Every bank holds the full 64K x 8 table. A load writes all banks at the
// same address; each bank serves one byte lane of a mix with a
// registered read.
// ---------------------------------------------------------------------------
`default_nettype none

module tkw_table
  import tkw_pkg::*;
(
  input  wire logic                    clk_i,
  input  wire tbl_req_t                req_i,
  output logic [LANES*BYTE_W-1:0]      rdata_o
);

  for (genvar g = 0; g < LANES; g++) begin : g_bank
    logic [BYTE_W-1:0] bank_q [TBL_DEPTH];
    logic [BYTE_W-1:0] rd_q;

    // Write on load, read on lookup issue; hold read data otherwise
    always_ff @(posedge clk_i) begin
      if (req_i.we) begin
        bank_q[req_i.waddr] <= req_i.wdata;
      end
      if (req_i.re) begin
        rd_q <= bank_q[req_i.raddr[g]];
      end
    end

    assign rdata_o[g*BYTE_W +: BYTE_W] = rd_q;
  end

endmodule

`default_nettype wire

// ----- hw/rtl/tkw_ctrl.sv -----
// ---------------------------------------------------------------------------
// tkw_ctrl: word sequencer with running key state
// Issues the dependent table lookups of one word, folds the returned bytes
// into key and subkey, tracks the block position and holds the result beat.
// ---------------------------------------------------------------------------
`default_nettype none

module tkw_ctrl
  import tkw_pkg::*;
#(
  parameter int unsigned MaxBlockWords = 4096
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire cfg_t                    cfg_i,
  input  wire logic                    in_valid_i,
  output logic                         in_ready_o,
  input  wire req_t                    in_data_i,
  output logic                         out_valid_o,
  input  wire logic                    out_ready_i,
  output rsp_t                         out_data_o,
  output tbl_req_t                     tbl_req_o,
  input  wire logic [LANES*BYTE_W-1:0] tbl_rdata_i,
  output seq_stat_t                    stat_o
);

  localparam int unsigned PosW = (MaxBlockWords > 1) ? $clog2(MaxBlockWords) : 1;
  localparam int unsigned CmpW = (PosW + 1 > BLOCK_W) ? PosW + 1 : BLOCK_W;
  localparam logic [CmpW-1:0] MaxLen = CmpW'(MaxBlockWords);

  // Sequencer phases: which lookup result arrives in this cycle
  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_MIXK = 2'd1;
  localparam logic [1:0] PH_MIXS = 2'd2;
  localparam logic [1:0] PH_MIXP = 2'd3;

  logic [1:0]        phase_q, phase_d;
  logic [WORD_W-1:0] key_q, key_d;
  logic [WORD_W-1:0] sub_q, sub_d;
  logic [PosW-1:0]   pos_q, pos_d;
  logic [WORD_W-1:0] data_q, data_d;
  logic              last_q, last_d;
  logic              out_valid_q, out_valid_d;
  rsp_t              out_data_q;

  logic [WORD_W-1:0] mix_res, key_fwd, res, plain;
  logic [WORD_W-1:0] a_op, b_op;
  logic              rd_en;
  logic              in_acc, can_emit, emit;
  logic [CmpW-1:0]   bw_ext, len, pos_inc;
  logic              last_w;
  logic [PosW-1:0]   pos_nxt;

  // Rotate looked-up bytes: lane 0 on top, then lanes 3, 2, 1
  assign mix_res = {tbl_rdata_i[7:0], tbl_rdata_i[31:24],
                    tbl_rdata_i[23:16], tbl_rdata_i[15:8]};

  // Forward the final key update to a word issued in the same cycle
  assign key_fwd = (phase_q == PH_MIXP) ? mix_res : key_q;

  assign res   = data_q ^ key_q;
  assign plain = cfg_i.cipher_mode ? res : data_q;

  assign in_ready_o = (phase_q == PH_IDLE) || (phase_q == PH_MIXP);
  assign in_acc     = in_valid_i && in_ready_o;
  assign can_emit   = !out_valid_q || out_ready_i;
  assign emit       = (phase_q == PH_MIXS) && can_emit;

  // Clamp block length and find the end of the block
  always_comb begin
    bw_ext = CmpW'(cfg_i.block_words);
    if (bw_ext == '0) begin
      len = CmpW'(1);
    end else if (bw_ext > MaxLen) begin
      len = MaxLen;
    end else begin
      len = bw_ext;
    end
    pos_inc = CmpW'(pos_q) + CmpW'(1);
    last_w  = (pos_inc >= len);
    pos_nxt = last_w ? '0 : pos_inc[PosW-1:0];
  end

  // Advance the lookup chain and take new beats
  always_comb begin
    phase_d = phase_q;
    key_d   = key_q;
    sub_d   = sub_q;
    pos_d   = pos_q;
    data_d  = data_q;
    last_d  = last_q;
    a_op    = '0;
    b_op    = '0;
    rd_en   = 1'b0;

    case (phase_q)
      PH_MIXK: begin
        key_d   = mix_res;
        a_op    = sub_q;
        b_op    = mix_res | sub_q;
        rd_en   = 1'b1;
        phase_d = PH_MIXS;
      end
      PH_MIXS: begin
        if (can_emit) begin
          sub_d   = mix_res;
          a_op    = key_q;
          b_op    = plain & mix_res;
          rd_en   = 1'b1;
          phase_d = PH_MIXP;
        end
      end
      PH_MIXP: begin
        key_d   = mix_res;
        phase_d = PH_IDLE;
      end
      default: begin
      end
    endcase

    if (in_acc) begin
      case (in_data_i.req_type)
        REQ_WORD: begin
          data_d = in_data_i.data_word;
          last_d = last_w;
          pos_d  = pos_nxt;
          rd_en  = 1'b1;
          if (pos_q == '0) begin
            a_op    = key_fwd;
            b_op    = sub_q;
            phase_d = PH_MIXK;
          end else begin
            a_op    = sub_q;
            b_op    = key_fwd | sub_q;
            phase_d = PH_MIXS;
          end
        end
        REQ_RESTART: begin
          key_d = cfg_i.start_key;
          sub_d = cfg_i.start_subkey;
          pos_d = '0;
        end
        default: begin
        end
      endcase
    end
  end

  // Table request: loads write, lookups read one address per lane
  always_comb begin
    tbl_req_o.we    = in_acc && (in_data_i.req_type == REQ_LOAD);
    tbl_req_o.waddr = in_data_i.table_index;
    tbl_req_o.wdata = in_data_i.table_byte;
    tbl_req_o.re    = rd_en;
    for (int k = 0; k < LANES; k++) begin
      tbl_req_o.raddr[k] = {a_op[k*BYTE_W +: BYTE_W], b_op[k*BYTE_W +: BYTE_W]};
    end
  end

  // Hold the result beat until taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      key_q       <= '0;
      sub_q       <= '0;
      pos_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      key_q       <= key_d;
      sub_q       <= sub_d;
      pos_q       <= pos_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
    last_q <= last_d;
    if (emit) begin
      out_data_q.data_out   <= res;
      out_data_q.block_last <= last_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign stat_o.busy = (phase_q == PH_MIXK) || (phase_q == PH_MIXS);
  assign stat_o.emit = emit;

endmodule

`default_nettype wire

// ----- hw/rtl/table_keyed_word_stream_cipher_top.sv -----
// ---------------------------------------------------------------------------
// table_keyed_word_stream_cipher_top: word stream cipher keyed by a table
// Configuration registers, the four-bank substitution table and the word
// sequencer.
//
//   channel  direction  handshake              beat
//   in       input      in_valid_i/in_ready_o  req_t (load, word, restart)
//   out      output     out_valid_o/out_ready_i rsp_t (data_out, block_last)
//   cfg      input      cfg_we_i               cfg_idx_i, cfg_wdata_i
//
// A data word runs through dependent mixes, each a registered read of the
// table banks: subkey, then key, after an extra key mix at a block's first
// word. The next beat is taken in a word's last cycle. Loads, restarts and
// unknown requests start no lookups. The result beat sits in an output
// register; a stall there holds the sequencer before its last lookup. Reset
// clears key, subkey, block position and registers; the table is kept.
// ---------------------------------------------------------------------------
`default_nettype none

module table_keyed_word_stream_cipher_top
  import tkw_pkg::*;
#(
  parameter int unsigned MaxBlockWords = 4096
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire req_t              in_data_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output rsp_t                   out_data_o,
  input  wire logic              cfg_we_i,
  input  wire logic [1:0]        cfg_idx_i,
  input  wire logic [WORD_W-1:0] cfg_wdata_i
);

  cfg_t                    cfg_q;
  tbl_req_t                tbl_req;
  logic [LANES*BYTE_W-1:0] tbl_rdata;
  seq_stat_t               stat;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.cipher_mode  <= 1'b0;
      cfg_q.block_words  <= BLOCK_W'(1);
      cfg_q.start_key    <= '0;
      cfg_q.start_subkey <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_MODE:         cfg_q.cipher_mode  <= cfg_wdata_i[0];
        CFG_BLOCK_WORDS:  cfg_q.block_words  <= cfg_wdata_i[BLOCK_W-1:0];
        CFG_START_KEY:    cfg_q.start_key    <= cfg_wdata_i;
        CFG_START_SUBKEY: cfg_q.start_subkey <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  tkw_table u_table (
    .clk_i   (clk_i),
    .req_i   (tbl_req),
    .rdata_o (tbl_rdata)
  );

  tkw_ctrl #(
    .MaxBlockWords (MaxBlockWords)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .tbl_req_o   (tbl_req),
    .tbl_rdata_i (tbl_rdata),
    .stat_o      (stat)
  );

  // No new beat while earlier lookups of a word are in flight
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.busy |-> !in_ready_o)
    else $error("input ready while a word is mid-chain");

  // A finished word shows up on the output in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.emit |=> out_valid_o)
    else $error("emitted result not presented");

  // Never overwrite a held result beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |-> !stat.emit)
    else $error("result beat overwritten");

  // A table load never coincides with a lookup
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(tbl_req.we && tbl_req.re))
    else $error("table write and read in the same cycle");

endmodule

`default_nettype wire

// ----- verif/tkw_checker.sv -----
// ---------------------------------------------------------------------------
// tkw_checker: result predictor and comparator for the table-keyed cipher
// Watches the request, result and configuration ports and keeps a private
// copy of the substitution table, the running key and subkey and the block
// position. Every accepted word request queues the word it must come back as;
// every accepted result beat is compared field by field with the oldest one.
// ---------------------------------------------------------------------------
`default_nettype none

module tkw_checker
  import tkw_pkg::*;
#(
  parameter int unsigned MaxBlockWords = 4096
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  input  wire logic              in_ready_i,
  input  wire req_t              in_data_i,
  input  wire logic              out_valid_i,
  input  wire logic              out_ready_i,
  input  wire rsp_t              out_data_i,
  input  wire logic              cfg_we_i,
  input  wire logic [1:0]        cfg_idx_i,
  input  wire logic [WORD_W-1:0] cfg_wdata_i,
  output int                     pending_o,
  output int                     errors_o
);

  // Shadow of the table; only entries written by a load are ever read
  logic [BYTE_W-1:0]  sbox [TBL_DEPTH];

  logic               cipher_mode;
  logic [BLOCK_W-1:0] block_words;
  logic [WORD_W-1:0]  start_key;
  logic [WORD_W-1:0]  start_subkey;

  logic [WORD_W-1:0]  key_q;
  logic [WORD_W-1:0]  subkey_q;
  int unsigned        word_pos;

  rsp_t               crypt_words_q [$];

  // Look up one table byte per lane and rotate: lane 0 lands on top
  function automatic logic [WORD_W-1:0] table_mix(input logic [WORD_W-1:0] a,
                                                  input logic [WORD_W-1:0] b);
    logic [BYTE_W-1:0] t [LANES];
    for (int k = 0; k < LANES; k++) begin
      t[k] = sbox[{a[8*k +: 8], b[8*k +: 8]}];
    end
    return {t[0], t[3], t[2], t[1]};
  endfunction

  // Advance key and subkey by one word and queue the word it turns into
  task automatic crypt_word(input logic [WORD_W-1:0] data);
    rsp_t              r;
    logic [WORD_W-1:0] plain;
    int unsigned       len;
    len = 32'(block_words);
    if (len == 0) len = 1;
    if (len > MaxBlockWords) len = MaxBlockWords;
    // Remix the key at the head of each block
    if (word_pos == 0) key_q = table_mix(key_q, subkey_q);
    subkey_q     = table_mix(subkey_q, key_q | subkey_q);
    r.data_out   = data ^ key_q;
    plain        = cipher_mode ? r.data_out : data;
    key_q        = table_mix(key_q, plain & subkey_q);
    // A shrunk block length ends the block at once
    r.block_last = (word_pos + 1 >= len);
    word_pos     = r.block_last ? 0 : word_pos + 1;
    crypt_words_q.push_back(r);
  endtask

  task automatic flag_mismatch(input string msg);
    $display("[%0t] tkw_checker: %s", $time, msg);
    errors_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    rsp_t want;
    if (!rst_ni) begin
      cipher_mode  = 1'b0;
      block_words  = BLOCK_W'(1);
      start_key    = '0;
      start_subkey = '0;
      key_q        = '0;
      subkey_q     = '0;
      word_pos     = 0;
      crypt_words_q.delete();
      pending_o    = 0;
      errors_o     = 0;
    end else begin
      // Compare a result beat with the oldest queued word
      if (out_valid_i && out_ready_i) begin
        if (crypt_words_q.size() == 0) begin
          flag_mismatch($sformatf("result beat %h/%0b with no word pending",
                                  out_data_i.data_out, out_data_i.block_last));
        end else begin
          want = crypt_words_q.pop_front();
          if (out_data_i.data_out !== want.data_out)
            flag_mismatch($sformatf("data_out %h, want %h",
                                    out_data_i.data_out, want.data_out));
          if (out_data_i.block_last !== want.block_last)
            flag_mismatch($sformatf("block_last %0b, want %0b (data_out %h)",
                                    out_data_i.block_last, want.block_last,
                                    want.data_out));
        end
      end
      // Apply a request beat
      if (in_valid_i && in_ready_i) begin
        case (in_data_i.req_type)
          REQ_LOAD: begin
            sbox[in_data_i.table_index] = in_data_i.table_byte;
          end
          REQ_WORD: begin
            crypt_word(in_data_i.data_word);
          end
          REQ_RESTART: begin
            key_q    = start_key;
            subkey_q = start_subkey;
            word_pos = 0;
          end
          default: begin
            // Drop unknown requests
          end
        endcase
      end
      // Track register writes
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_MODE:         cipher_mode  = cfg_wdata_i[0];
          CFG_BLOCK_WORDS:  block_words  = cfg_wdata_i[BLOCK_W-1:0];
          CFG_START_KEY:    start_key    = cfg_wdata_i;
          CFG_START_SUBKEY: start_subkey = cfg_wdata_i;
          default: begin
          end
        endcase
      end
      pending_o = crypt_words_q.size();
    end
  end

endmodule

`default_nettype wire

// ----- verif/tb.sv -----
// ---------------------------------------------------------------------------
// tb: stimulus and verdict for the table-keyed word stream cipher
// Fills the table rows that key and subkey bytes can reach, runs a short
// directed sequence over block boundaries, modes and register extremes, then
// random phases of words, restarts, table loads and unknown requests under
// random settings, with random gaps on the request side and random stalls on
// the result side. Table bytes and start keys are built from a small byte
// set that is closed under OR, so every lookup lands in a filled row.
// ---------------------------------------------------------------------------
`default_nettype none

module tb;
  import tkw_pkg::*;

  localparam logic [1:0]  REQ_UNUSED    = 2'd3;
  localparam int unsigned MaxBlockWords = 4096;
  localparam int          ItemTarget    = 1800;
  localparam int          StallLimit    = 1000;
  localparam int          SettleCycles  = 8;
  localparam int          KeyRows       = 4;

  logic              clk       = 1'b0;
  logic              rst_n     = 1'b0;
  logic              in_valid  = 1'b0;
  logic              in_ready;
  req_t              in_data   = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  rsp_t              out_data;
  logic              cfg_we    = 1'b0;
  logic [1:0]        cfg_idx   = CFG_MODE;
  logic [WORD_W-1:0] cfg_wdata = '0;

  int mismatches;
  int words_pending;
  int items_sent  = 0;
  int idle_cycles = 0;
  bit quiet_phase = 1'b0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  table_keyed_word_stream_cipher_top #(
    .MaxBlockWords(MaxBlockWords)
  ) uut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata)
  );

  tkw_checker #(
    .MaxBlockWords(MaxBlockWords)
  ) tkw_chk (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_i (in_ready),
    .in_data_i  (in_data),
    .out_valid_i(out_valid),
    .out_ready_i(out_ready),
    .out_data_i (out_data),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata),
    .pending_o  (words_pending),
    .errors_o   (mismatches)
  );

  // Byte set for table contents and key bytes; OR of two members stays inside
  function automatic logic [BYTE_W-1:0] row_byte(input int sel);
    case (sel)
      0:       return 8'h00;
      1:       return 8'h0f;
      2:       return 8'hf0;
      default: return 8'hff;
    endcase
  endfunction

  function automatic logic [BYTE_W-1:0] pick_byte();
    return row_byte($urandom_range(0, KeyRows - 1));
  endfunction

  // Build a request beat; table index and table byte are random, the data word is given
  function automatic req_t make_beat(input logic [1:0] kind,
                                     input logic [WORD_W-1:0] word);
    req_t b;
    b.req_type    = kind;
    b.table_index = 16'($urandom);
    b.table_byte  = pick_byte();
    b.data_word   = word;
    return b;
  endfunction

  function automatic logic [WORD_W-1:0] pick_key();
    int r;
    logic [WORD_W-1:0] k;
    r = $urandom_range(0, 19);
    if (r < 2) return '0;
    if (r < 4) return '1;
    for (int i = 0; i < LANES; i++) k[8*i +: 8] = pick_byte();
    return k;
  endfunction

  // Hold the beat until accepted, after an optional random gap
  task automatic send_beat(input req_t beat);
    int r;
    int gap;
    r   = $urandom_range(0, 99);
    gap = (quiet_phase || r < 60) ? 0 :
          (r < 92) ? $urandom_range(1, 3) : $urandom_range(8, 40);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= beat;
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
    if (beat.req_type != REQ_UNUSED) items_sent++;
  endtask

  task automatic send_word(input logic [WORD_W-1:0] word);
    send_beat(make_beat(REQ_WORD, word));
  endtask

  // Hold off requests until every queued word is back, then let the block settle
  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (words_pending != 0);
    repeat (SettleCycles) @(posedge clk);
  endtask

  // Write all four registers, one after another; call only when idle
  task automatic set_config(input logic mode, input logic [BLOCK_W-1:0] blk,
                            input logic [WORD_W-1:0] skey,
                            input logic [WORD_W-1:0] ssub);
    cfg_we    <= 1'b1;
    cfg_idx   <= CFG_MODE;
    cfg_wdata <= WORD_W'(mode);
    @(posedge clk);
    cfg_idx   <= CFG_BLOCK_WORDS;
    cfg_wdata <= WORD_W'(blk);
    @(posedge clk);
    cfg_idx   <= CFG_START_KEY;
    cfg_wdata <= skey;
    @(posedge clk);
    cfg_idx   <= CFG_START_SUBKEY;
    cfg_wdata <= ssub;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Result side: ready runs of random length, mostly short stalls, a few long
  initial begin
    int run;
    int stall;
    int r;
    @(posedge rst_n);
    forever begin
      run = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 300) : $urandom_range(1, 8);
      out_ready <= 1'b1;
      repeat (run) @(posedge clk);
      r     = $urandom_range(0, 99);
      stall = (r < 50) ? 0 : (r < 92) ? $urandom_range(1, 3) : $urandom_range(10, 40);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= StallLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    req_t             beat;
    int               r;
    int               n;
    logic [1:0]       kind;
    logic [BLOCK_W-1:0] blk;
    logic [WORD_W-1:0]  word;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Fill every row that a key or subkey byte can select
    quiet_phase = 1'b1;
    for (int row = 0; row < KeyRows; row++) begin
      for (int col = 0; col < 256; col++) begin
        beat             = make_beat(REQ_LOAD, $urandom);
        beat.table_index = {row_byte(row), 8'(col)};
        send_beat(beat);
      end
    end
    quiet_phase = 1'b0;

    // Directed: reset key state, one-word blocks, extreme data, unknown request
    send_word('0);
    send_word('1);
    send_beat(make_beat(REQ_UNUSED, 32'ha5a5a5a5));

    // Three-word blocks, restart, a table write in mid stream
    drain();
    set_config(1'b0, 13'd3, '0, '1);
    send_beat(make_beat(REQ_RESTART, '0));
    send_word(32'h12345678);
    send_word(32'h0);
    send_beat(make_beat(REQ_LOAD, '0));
    send_word('1);
    send_word($urandom);

    // Decrypt, eight-word blocks, stop five words in
    drain();
    set_config(1'b1, 13'd8, '1, '0);
    send_beat(make_beat(REQ_RESTART, '0));
    repeat (5) send_word($urandom);

    // Shrink the block below the current position: next word ends the block
    drain();
    set_config(1'b1, 13'd2, '1, '0);
    send_word($urandom);
    send_word($urandom);

    // Zero block length acts as one word
    drain();
    set_config(1'b0, 13'd0, 32'h0ff0f00f, 32'hf00ff00f);
    send_beat(make_beat(REQ_RESTART, '0));
    send_word($urandom);
    send_word($urandom);

    // Oversized block length is clipped
    drain();
    set_config(1'b1, 13'h1fff, pick_key(), pick_key());
    send_beat(make_beat(REQ_RESTART, '0));
    send_word($urandom);
    send_word($urandom);

    // Random phases under random settings
    while (items_sent < ItemTarget) begin
      drain();
      quiet_phase = ($urandom_range(0, 3) == 0);
      r   = $urandom_range(0, 19);
      blk = (r == 0) ? 13'd0 :
            (r == 1) ? BLOCK_W'(MaxBlockWords) :
            (r == 2) ? 13'h1fff :
            (r == 3) ? BLOCK_W'($urandom_range(1, 8191)) :
                       BLOCK_W'($urandom_range(1, 9));
      set_config(1'($urandom), blk, pick_key(), pick_key());
      if ($urandom_range(0, 7) != 0) send_beat(make_beat(REQ_RESTART, $urandom));
      n = $urandom_range(20, 120);
      repeat (n) begin
        r    = $urandom_range(0, 99);
        kind = (r < 84) ? REQ_WORD : (r < 91) ? REQ_RESTART :
               (r < 97) ? REQ_LOAD : REQ_UNUSED;
        r    = $urandom_range(0, 99);
        word = (r < 4) ? '0 : (r < 8) ? '1 : $urandom;
        send_beat(make_beat(kind, word));
        // Now and then let every result come home before going on
        if ($urandom_range(0, 149) == 0) drain();
      end
    end

    drain();
    @(negedge clk);
    if (mismatches == 0 && words_pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- files.f -----
hw/rtl/tkw_pkg.sv
hw/rtl/tkw_table.sv
hw/rtl/tkw_ctrl.sv
hw/rtl/table_keyed_word_stream_cipher_top.sv
verif/tkw_checker.sv
verif/tb.sv
